### rtl/vgmcp_pkg.sv
// ----------------------------------------------------------------------------
// vgmcp_pkg: shared types and constants for the VGM command stream parser
// Command codes, event kinds, configuration indexes and request structs.
// ----------------------------------------------------------------------------
`default_nettype none

package vgmcp_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_START = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_LIMIT = 1'd1;
  localparam logic [7:0] LOOP_LIMIT_RESET = 8'd2;

  // Depth of the queue between parser and event output
  localparam int QUEUE_DEPTH = 4;

  // Command bytes
  localparam logic [7:0] CMD_WAIT_N        = 8'h61;
  localparam logic [7:0] CMD_WAIT_NTSC     = 8'h62;
  localparam logic [7:0] CMD_WAIT_PAL      = 8'h63;
  localparam logic [7:0] CMD_END           = 8'h66;
  localparam logic [7:0] CMD_DATA_BLOCK    = 8'h67;
  localparam logic [7:0] CMD_PORT_WRITE    = 8'hbc;
  localparam logic [7:0] CMD_RAM_WRITE     = 8'hc6;
  localparam logic [7:0] CMD_SKIP_B3       = 8'hb3;
  localparam logic [7:0] CMD_STEREO        = 8'h4f;
  localparam logic [7:0] CMD_PSG           = 8'h50;
  localparam logic [7:0] CMD_REG_LO        = 8'h51;
  localparam logic [7:0] CMD_REG_HI        = 8'h5f;
  localparam logic [7:0] CMD_SHORT_WAIT_LO = 8'h70;
  localparam logic [7:0] CMD_SHORT_WAIT_HI = 8'h7f;

  localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
  localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;
  localparam logic [3:0]  SHORT_WAIT_MASK   = 4'hf;
  localparam logic [7:0]  PORT_BASE         = 8'h80;

  typedef enum logic [2:0] {
    EV_WAIT = 3'd0,
    EV_PORT = 3'd1,
    EV_RAM  = 3'd2,
    EV_SEEK = 3'd3,
    EV_END  = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [15:0] wait_samples;
    logic [7:0]  port_number;
    logic [15:0] ram_address;
    logic [7:0]  write_value;
    logic [31:0] seek_offset;
    logic        truncated;
    logic        last_of_run;
  } result_t;

  // One parsed byte: an optional decoded event, then an optional end of run.
  typedef struct packed {
    logic    evt_valid;
    result_t evt;
    logic    end_valid;
    logic    end_trunc;
  } rec_t;

endpackage

`default_nettype wire

### rtl/vgm_command_stream_parser_top.sv
// ----------------------------------------------------------------------------
// vgm_command_stream_parser_top: VGM command byte stream to event requests
// Each accepted byte's record is registered in the record queue, which presents it as a result.
// One byte is accepted per cycle while the queue is not full; one result is popped
// per cycle, so a byte with two results needs two pops.
// Reset (rst, sync): parser idle, queue empty, loop start 0, loop limit 2.
// ----------------------------------------------------------------------------
`default_nettype none

module vgm_command_stream_parser_top #(
  parameter int QUEUE_DEPTH = vgmcp_pkg::QUEUE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // byte input, queue style
  input  wire logic                              push,
  output logic                                   full,
  input  wire vgmcp_pkg::in_item_t               item,
  // event output, queue style
  output logic                                   empty,
  input  wire logic                              pop,
  output vgmcp_pkg::result_t                     result,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [vgmcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [vgmcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vgmcp_pkg::*;

  // Front: decodes one byte per accepted request and updates parser state
  // in the same cycle. Back: presents queued records, splitting a record that
  // carries an event plus an end of run into two result requests.
  // The queue keeps the front running while results wait to be popped;
  // full reflects only queue occupancy.

  logic accept;
  rec_t front_rec;
  logic front_push;
  rec_t head_rec;
  logic head_empty;
  logic head_pop;

  assign accept = push && !full;

  vgmcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec       (front_rec),
    .rec_push  (front_push)
  );

  vgmcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_rec),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head_rec),
    .empty   (head_empty)
  );

  vgmcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (head_rec),
    .rec_empty (head_empty),
    .rec_pop   (head_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

### rtl/vgmcp_front.sv
// ----------------------------------------------------------------------------
// vgmcp_front: byte parser
// Tracks the command state, decodes each accepted byte into a record.
// ----------------------------------------------------------------------------
`default_nettype none

module vgmcp_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire vgmcp_pkg::in_item_t               item,
  input  wire logic                              cfg_we,
  input  wire logic [vgmcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [vgmcp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output vgmcp_pkg::rec_t                        rec,
  output logic                                   rec_push
);
  import vgmcp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ARGS = 3'b010,
    PH_SKIP = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  cmd, cmd_next;
  logic [31:0] args, args_next;
  logic [2:0]  args_left, args_left_next;
  logic [31:0] skip, skip_next;
  logic [7:0]  loops_taken, loops_taken_next;
  logic [31:0] loop_start;
  logic [7:0]  loop_limit;

  logic        seeking;
  logic        early_end;
  logic [31:0] arg_shift;
  logic [2:0]  left_dec;
  logic [31:0] skip_dec;
  logic [7:0]  b;

  assign b = item.data_byte;

  always_comb begin
    phase_next       = phase;
    cmd_next         = cmd;
    args_next        = args;
    args_left_next   = args_left;
    skip_next        = skip;
    loops_taken_next = loops_taken;
    rec              = '0;
    seeking          = 1'b0;
    early_end        = 1'b0;
    arg_shift        = {b, args[31:8]};
    left_dec         = (args_left != 3'd0) ? args_left - 3'd1 : args_left;
    skip_dec         = (skip != 32'd0) ? skip - 32'd1 : skip;

    unique case (phase)
      PH_ARGS: begin
        args_next      = arg_shift;
        args_left_next = left_dec;
        if (left_dec == 3'd0) begin
          phase_next = PH_IDLE;
          case (cmd)
            CMD_WAIT_N: begin
              rec.evt_valid        = 1'b1;
              rec.evt.event_kind   = EV_WAIT;
              rec.evt.wait_samples = arg_shift[31:16];
            end
            CMD_PORT_WRITE: begin
              rec.evt_valid       = 1'b1;
              rec.evt.event_kind  = EV_PORT;
              rec.evt.port_number = PORT_BASE + arg_shift[23:16];
              rec.evt.write_value = arg_shift[31:24];
            end
            CMD_RAM_WRITE: begin
              rec.evt_valid       = 1'b1;
              rec.evt.event_kind  = EV_RAM;
              rec.evt.ram_address = {arg_shift[15:8], arg_shift[23:16]};
              rec.evt.write_value = arg_shift[31:24];
            end
            CMD_DATA_BLOCK: begin
              if (arg_shift != 32'd0) begin
                phase_next = PH_SKIP;
                skip_next  = arg_shift;
              end
            end
            default: ;
          endcase
        end
      end
      PH_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_next = PH_IDLE;
        end
      end
      PH_IDLE: begin
        cmd_next = b;
        unique case (b) inside
          CMD_END: begin
            rec.evt_valid = 1'b1;
            if (loop_start != 32'd0 && loops_taken < loop_limit) begin
              loops_taken_next    = loops_taken + 8'd1;
              rec.evt.event_kind  = EV_SEEK;
              rec.evt.seek_offset = loop_start;
              seeking             = 1'b1;
            end else begin
              rec.evt.event_kind = EV_END;
              early_end          = 1'b1;
            end
          end
          CMD_WAIT_N, CMD_PORT_WRITE: begin
            phase_next     = PH_ARGS;
            args_next      = 32'd0;
            args_left_next = 3'd2;
          end
          CMD_RAM_WRITE: begin
            phase_next     = PH_ARGS;
            args_next      = 32'd0;
            args_left_next = 3'd3;
          end
          CMD_DATA_BLOCK: begin
            phase_next     = PH_ARGS;
            args_next      = 32'd0;
            args_left_next = 3'd6;
          end
          CMD_WAIT_NTSC: begin
            rec.evt_valid        = 1'b1;
            rec.evt.event_kind   = EV_WAIT;
            rec.evt.wait_samples = WAIT_NTSC_SAMPLES;
          end
          CMD_WAIT_PAL: begin
            rec.evt_valid        = 1'b1;
            rec.evt.event_kind   = EV_WAIT;
            rec.evt.wait_samples = WAIT_PAL_SAMPLES;
          end
          [CMD_SHORT_WAIT_LO:CMD_SHORT_WAIT_HI]: begin
            rec.evt_valid        = 1'b1;
            rec.evt.event_kind   = EV_WAIT;
            rec.evt.wait_samples = {12'd0, b[3:0] & SHORT_WAIT_MASK} + 16'd1;
          end
          CMD_SKIP_B3, [CMD_REG_LO:CMD_REG_HI]: begin
            phase_next = PH_SKIP;
            skip_next  = 32'd2;
          end
          CMD_STEREO, CMD_PSG: begin
            phase_next = PH_SKIP;
            skip_next  = 32'd1;
          end
          default: ;
        endcase
      end
      default: phase_next = PH_IDLE;
    endcase

    // last byte that neither seeks nor ends: end of run, flagged truncated if a command is still open
    if (item.end_of_data && !seeking && !early_end) begin
      rec.end_valid = 1'b1;
      rec.end_trunc = (phase_next != PH_IDLE);
    end

    if (early_end || (item.end_of_data && !seeking)) begin
      phase_next       = PH_IDLE;
      cmd_next         = 8'd0;
      args_next        = 32'd0;
      args_left_next   = 3'd0;
      skip_next        = 32'd0;
      loops_taken_next = 8'd0;
    end
  end

  assign rec_push = accept && (rec.evt_valid || rec.end_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cmd         <= 8'd0;
      args        <= 32'd0;
      args_left   <= 3'd0;
      skip        <= 32'd0;
      loops_taken <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      cmd         <= cmd_next;
      args        <= args_next;
      args_left   <= args_left_next;
      skip        <= skip_next;
      loops_taken <= loops_taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_start <= 32'd0;
      loop_limit <= LOOP_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOOP_START: loop_start <= cfg_data;
        CFG_LOOP_LIMIT: loop_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // argument phase always has bytes outstanding
  a_args_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ARGS) |-> (args_left != 3'd0))
    else $error("argument phase with no bytes left");

  // a last byte that does not seek rearms the parser
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_data && !seeking) |=>
      (phase == PH_IDLE && loops_taken == 8'd0))
    else $error("parser not rearmed after end of data");
`endif

endmodule

`default_nettype wire

### rtl/vgmcp_queue.sv
// ----------------------------------------------------------------------------
// vgmcp_queue: record queue
// Small register queue between the parser and the event output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vgmcp_queue #(
  parameter int DEPTH = vgmcp_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire vgmcp_pkg::rec_t wr_data,
  output logic                 full,
  input  wire logic            rd_en,
  output vgmcp_pkg::rec_t      rd_data,
  output logic                 empty
);
  import vgmcp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!full || rd_en))
    else $error("record queue overflow");
`endif

endmodule

`default_nettype wire

### rtl/vgmcp_back.sv
// ----------------------------------------------------------------------------
// vgmcp_back: event output stage
// Expands each queued record into one or two result requests.
// ----------------------------------------------------------------------------
`default_nettype none

module vgmcp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire vgmcp_pkg::rec_t    rec,
  input  wire logic               rec_empty,
  output logic                    rec_pop,
  output vgmcp_pkg::result_t      result,
  output logic                    empty,
  input  wire logic               pop
);
  import vgmcp_pkg::*;

  logic    tail;       // first event of a two-result record already taken
  logic    take;
  logic    show_end;
  result_t end_res;

  assign empty    = rec_empty;
  assign take     = pop && !rec_empty;
  assign show_end = tail || !rec.evt_valid;

  always_comb begin
    end_res            = '0;
    end_res.event_kind = EV_END;
    end_res.truncated  = rec.end_trunc;
    end_res.last_of_run = 1'b1;
    if (show_end) begin
      result = end_res;
    end else begin
      result             = rec.evt;
      result.last_of_run = !rec.end_valid;
    end
  end

  assign rec_pop = take && (show_end || !rec.end_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      tail <= 1'b0;
    end else if (take) begin
      tail <= !show_end && rec.end_valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_tail_held: assert property (@(posedge clk) disable iff (rst)
    tail |-> (!rec_empty && rec.evt_valid && rec.end_valid))
    else $error("pending end lost its record");
`endif

endmodule

`default_nettype wire
